[hdl/rwt_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the retransmit window tracker.
// Depends on nothing; used by retransmit_window_tracker.
package rwt_pkg;

   localparam int SLOTS_DEFAULT = 64;
   localparam int SEQ_W         = 16;
   localparam int TIME_W        = 48;
   localparam int SLOT_W        = 6;
   localparam int RESEND_W      = 8;
   localparam int COUNT_W       = 7;
   localparam int MAX_ACK       = 64;

   localparam logic [TIME_W-1:0] TIMEOUT_DEFAULT = TIME_W'(200 * 1000 * 1000);

   localparam logic [1:0] REQ_ALLOC = 2'd0;
   localparam logic [1:0] REQ_ACK   = 2'd1;
   localparam logic [1:0] REQ_TIMER = 2'd2;

   typedef enum logic [2:0] {
      EV_GRANT   = 3'd0,
      EV_RELEASE = 3'd1,
      EV_STALE   = 3'd2,
      EV_RESEND  = 3'd3,
      EV_BUSY    = 3'd4
   } event_type;

   // One window slot as kept in the slot memory.
   typedef struct packed {
      logic [SEQ_W-1:0]    seq;
      logic [TIME_W-1:0]   stamp;
      logic [RESEND_W-1:0] resends;
   } entry_type;

endpackage

[hdl/retransmit_window_tracker.sv]
`timescale 1ns / 1ps
// An allocate goes to S_ALLOC_RD, then S_ALLOC_EV puts its first result in the output register.
// An ack range finds its start slot in S_ACK_MUL, S_ACK_MOD; each number visits S_ACK_RD, S_ACK_EV.
// Timer check: a free slot takes S_TMR_RD, a busy one S_TMR_RD and S_TMR_EV; then S_TMR_DONE.
// Throughput: one item at a time; req_stall stays high until the sequencer is back in idle,
// and a stalled response port holds the sequencer wherever it has a result to hand over.
// Reset: synchronous; all slots free, next sequence 1, timeout 200000000; no clearing pass.
//
// Transmit-side sliding window with ack handling and retransmit scan.
// Depends on rwt_pkg.
module retransmit_window_tracker #(
   parameter int SLOTS = rwt_pkg::SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // Request channel.
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_type,
   input  logic [rwt_pkg::TIME_W-1:0]    req_time_now,
   input  logic                          req_has_messages,
   input  logic [rwt_pkg::SEQ_W-1:0]     req_ack_start,
   input  logic [rwt_pkg::COUNT_W-1:0]   req_ack_count,
   // Response channel.
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_event_res,
   output logic [rwt_pkg::SEQ_W-1:0]     rsp_seq_number,
   output logic [rwt_pkg::SLOT_W-1:0]    rsp_slot_index,
   output logic [rwt_pkg::RESEND_W-1:0]  rsp_resend_total,
   output logic                          rsp_last,
   // Timeout register write channel.
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rwt_pkg::TIME_W-1:0]    csr_data
);

   // Width of a slot index inside the block.
   localparam int IW = $clog2(SLOTS);

   // Scaled reciprocal of SLOTS. With a shift of 16 plus the index width the
   // quotient of every 16-bit number comes out exact after multiply and shift.
   localparam int RECIP_SHIFT = rwt_pkg::SEQ_W + IW;
   localparam int RECIP_W     = rwt_pkg::SEQ_W + 2;
   localparam int PROD_W      = rwt_pkg::SEQ_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((longint'(1) << RECIP_SHIFT) + longint'(SLOTS) - longint'(1))
               / longint'(SLOTS));

   // The sequencer. Every slot visit is a read state followed by an evaluate
   // state, so a write made while evaluating one slot is always seen by the
   // read of the next slot, even when an ack range revisits the same slot.
   typedef enum logic [3:0] {
      S_IDLE,
      S_ALLOC_RD,
      S_ALLOC_EV,
      S_ALLOC_REL,
      S_ACK_MUL,
      S_ACK_MOD,
      S_ACK_RD,
      S_ACK_EV,
      S_TMR_RD,
      S_TMR_EV,
      S_TMR_DONE
   } state_type;

   // Next slot after the given one. When the sequence number wraps from all
   // ones to zero, the slot goes back to zero as well, which matters when
   // SLOTS does not divide the sequence space.
   function automatic logic [IW-1:0] slot_step(input logic [IW-1:0] slot,
                                                input logic seq_wraps);
      logic [IW-1:0] result;
      if (seq_wraps || slot == IW'(SLOTS - 1)) begin
         result = '0;
      end else begin
         result = slot + IW'(1);
      end
      return result;
   endfunction

   // Control registers.
   state_type                         state_ff, state_in;
   logic [rwt_pkg::SEQ_W-1:0]         next_seq_ff, next_seq_in;
   logic [IW-1:0]                     next_slot_ff, next_slot_in;
   logic [SLOTS-1:0]                  busy_ff, busy_in;
   logic [rwt_pkg::TIME_W-1:0]        timeout_ff, timeout_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              pend_valid_ff, pend_valid_in;

   // Working registers of the item under way.
   logic [IW-1:0]                     slot_ff, slot_in;
   logic [rwt_pkg::SEQ_W-1:0]         seq_ff, seq_in;
   logic [rwt_pkg::TIME_W-1:0]        now_ff, now_in;
   logic                              has_msg_ff, has_msg_in;
   logic [rwt_pkg::COUNT_W-1:0]       left_ff, left_in;
   logic [PROD_W-1:0]                 prod_ff, prod_in;

   // Output register and the timer's held-back result.
   rwt_pkg::event_type                rsp_ev_ff, rsp_ev_in;
   logic [rwt_pkg::SEQ_W-1:0]         rsp_seq_ff, rsp_seq_in;
   logic [IW-1:0]                     rsp_slot_ff, rsp_slot_in;
   logic [rwt_pkg::RESEND_W-1:0]      rsp_tot_ff, rsp_tot_in;
   logic                              rsp_last_ff, rsp_last_in;
   logic [rwt_pkg::SEQ_W-1:0]         pend_seq_ff, pend_seq_in;
   logic [IW-1:0]                     pend_slot_ff, pend_slot_in;
   logic [rwt_pkg::RESEND_W-1:0]      pend_tot_ff, pend_tot_in;

   // Slot memory: one write port and one registered read port.
   rwt_pkg::entry_type                slot_mem [SLOTS];
   rwt_pkg::entry_type                rd_data_ff;
   rwt_pkg::entry_type                mem_wdata;
   logic                              mem_we;

   // Shared compare and stamp arithmetic.
   logic                              out_free;
   logic                              accept;
   logic [rwt_pkg::TIME_W:0]          age;
   logic                              due;
   logic                              slot_busy;
   logic [rwt_pkg::RESEND_W-1:0]      stored_tot;
   logic [rwt_pkg::RESEND_W-1:0]      bumped_tot;
   logic [rwt_pkg::SEQ_W-1:0]         quot;
   logic [IW-1:0]                     mod_value;
   logic [rwt_pkg::COUNT_W-1:0]       ack_count_sat;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // The output register can take a new item when it is empty or its item
   // leaves at this edge.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // A free slot reports a resend count of zero: release clears only its busy
   // bit, a grant writes a zero count, and only busy slots are resent. The memory
   // copy of a free slot is never trusted, so the count is read through the busy bit.
   assign slot_busy  = busy_ff[slot_ff];
   assign stored_tot = slot_busy ? rd_data_ff.resends : '0;
   assign bumped_tot = (rd_data_ff.resends == '1) ? rd_data_ff.resends
                                                  : rd_data_ff.resends + 8'd1;

   // The borrow bit of the age tells a stamp in the future; an age equal to
   // zero can never exceed the timeout, so the strict test covers both.
   assign age = {1'b0, now_ff} - {1'b0, rd_data_ff.stamp};
   assign due = !age[rwt_pkg::TIME_W] && (age[rwt_pkg::TIME_W-1:0] > timeout_ff);

   // Remainder of the ack start number: the registered product gives the
   // quotient, and one small multiply and subtract give the slot.
   assign quot      = rwt_pkg::SEQ_W'(prod_ff >> RECIP_SHIFT);
   assign mod_value = IW'(seq_ff - rwt_pkg::SEQ_W'(quot * rwt_pkg::SEQ_W'(SLOTS)));

   assign ack_count_sat = (req_ack_count > rwt_pkg::COUNT_W'(rwt_pkg::MAX_ACK))
                        ? rwt_pkg::COUNT_W'(rwt_pkg::MAX_ACK) : req_ack_count;

   always_comb begin
      state_in      = state_ff;
      next_seq_in   = next_seq_ff;
      next_slot_in  = next_slot_ff;
      busy_in       = busy_ff;
      timeout_in    = timeout_ff;
      pend_valid_in = pend_valid_ff;
      slot_in       = slot_ff;
      seq_in        = seq_ff;
      now_in        = now_ff;
      has_msg_in    = has_msg_ff;
      left_in       = left_ff;
      prod_in       = prod_ff;
      pend_seq_in   = pend_seq_ff;
      pend_slot_in  = pend_slot_ff;
      pend_tot_in   = pend_tot_ff;
      rsp_ev_in     = rsp_ev_ff;
      rsp_seq_in    = rsp_seq_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_tot_in    = rsp_tot_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      mem_we        = 1'b0;
      mem_wdata     = rd_data_ff;

      if (csr_valid && csr_ready) begin
         timeout_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               now_in     = req_time_now;
               has_msg_in = req_has_messages;
               unique case (req_type)
                  rwt_pkg::REQ_ALLOC: begin
                     // The sequence number is consumed even if the slot
                     // turns out to be busy.
                     seq_in       = next_seq_ff;
                     slot_in      = next_slot_ff;
                     next_seq_in  = next_seq_ff + 16'd1;
                     next_slot_in = slot_step(next_slot_ff, next_seq_ff == '1);
                     state_in     = S_ALLOC_RD;
                  end
                  rwt_pkg::REQ_ACK: begin
                     seq_in  = req_ack_start;
                     left_in = ack_count_sat;
                     if (ack_count_sat != '0) begin
                        state_in = S_ACK_MUL;
                     end
                  end
                  rwt_pkg::REQ_TIMER: begin
                     slot_in  = '0;
                     state_in = S_TMR_RD;
                  end
                  default: begin
                     // Unused request code: taken and dropped.
                  end
               endcase
            end
         end

         S_ALLOC_RD: begin
            state_in = S_ALLOC_EV;
         end

         S_ALLOC_EV: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_seq_in   = seq_ff;
               rsp_slot_in  = slot_ff;
               if (slot_busy) begin
                  rsp_ev_in   = rwt_pkg::EV_BUSY;
                  rsp_tot_in  = rd_data_ff.resends;
                  rsp_last_in = 1'b1;
                  state_in    = S_IDLE;
               end else begin
                  mem_we            = 1'b1;
                  mem_wdata.seq     = seq_ff;
                  mem_wdata.stamp   = now_ff;
                  mem_wdata.resends = '0;
                  busy_in[slot_ff]  = 1'b1;
                  rsp_ev_in         = rwt_pkg::EV_GRANT;
                  rsp_tot_in        = '0;
                  rsp_last_in       = has_msg_ff;
                  state_in          = has_msg_ff ? S_IDLE : S_ALLOC_REL;
               end
            end
         end

         S_ALLOC_REL: begin
            // A frame without messages is released right after its grant.
            if (out_free) begin
               busy_in[slot_ff] = 1'b0;
               rsp_valid_in     = 1'b1;
               rsp_ev_in        = rwt_pkg::EV_RELEASE;
               rsp_seq_in       = seq_ff;
               rsp_slot_in      = slot_ff;
               rsp_tot_in       = '0;
               rsp_last_in      = 1'b1;
               state_in         = S_IDLE;
            end
         end

         S_ACK_MUL: begin
            // Start number times the scaled reciprocal of SLOTS.
            prod_in  = PROD_W'(seq_ff) * PROD_W'(RECIP);
            state_in = S_ACK_MOD;
         end

         S_ACK_MOD: begin
            slot_in  = mod_value;
            state_in = S_ACK_RD;
         end

         S_ACK_RD: begin
            state_in = S_ACK_EV;
         end

         S_ACK_EV: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_seq_in   = seq_ff;
               rsp_slot_in  = slot_ff;
               rsp_last_in  = (left_ff == 7'd1);
               if (slot_busy && rd_data_ff.seq == seq_ff) begin
                  busy_in[slot_ff] = 1'b0;
                  rsp_ev_in        = rwt_pkg::EV_RELEASE;
                  rsp_tot_in       = '0;
               end else begin
                  rsp_ev_in  = rwt_pkg::EV_STALE;
                  rsp_tot_in = stored_tot;
               end
               if (left_ff == 7'd1) begin
                  state_in = S_IDLE;
               end else begin
                  left_in  = left_ff - 7'd1;
                  seq_in   = seq_ff + 16'd1;
                  slot_in  = slot_step(slot_ff, seq_ff == '1);
                  state_in = S_ACK_RD;
               end
            end
         end

         S_TMR_RD: begin
            // Free slots are passed over without a memory visit.
            if (slot_busy) begin
               state_in = S_TMR_EV;
            end else if (slot_ff == IW'(SLOTS - 1)) begin
               state_in = S_TMR_DONE;
            end else begin
               slot_in = slot_ff + IW'(1);
            end
         end

         S_TMR_EV: begin
            // The newest resend is held back until the scan shows whether it
            // is the final result; finding another one pushes it out first.
            if (!due || !pend_valid_ff || out_free) begin
               if (due) begin
                  mem_we            = 1'b1;
                  mem_wdata.stamp   = now_ff;
                  mem_wdata.resends = bumped_tot;
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_ev_in    = rwt_pkg::EV_RESEND;
                     rsp_seq_in   = pend_seq_ff;
                     rsp_slot_in  = pend_slot_ff;
                     rsp_tot_in   = pend_tot_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_seq_in   = rd_data_ff.seq;
                  pend_slot_in  = slot_ff;
                  pend_tot_in   = bumped_tot;
               end
               if (slot_ff == IW'(SLOTS - 1)) begin
                  state_in = S_TMR_DONE;
               end else begin
                  slot_in  = slot_ff + IW'(1);
                  state_in = S_TMR_RD;
               end
            end
         end

         S_TMR_DONE: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_ev_in     = rwt_pkg::EV_RESEND;
               rsp_seq_in    = pend_seq_ff;
               rsp_slot_in   = pend_slot_ff;
               rsp_tot_in    = pend_tot_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      seq_ff       <= seq_in;
      now_ff       <= now_in;
      has_msg_ff   <= has_msg_in;
      left_ff      <= left_in;
      prod_ff      <= prod_in;
      pend_seq_ff  <= pend_seq_in;
      pend_slot_ff <= pend_slot_in;
      pend_tot_ff  <= pend_tot_in;
      rsp_ev_ff    <= rsp_ev_in;
      rsp_seq_ff   <= rsp_seq_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_tot_ff   <= rsp_tot_in;
      rsp_last_ff  <= rsp_last_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         next_seq_ff   <= 16'd1;
         next_slot_ff  <= IW'(1);
         busy_ff       <= '0;
         timeout_ff    <= rwt_pkg::TIMEOUT_DEFAULT;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         next_seq_ff   <= next_seq_in;
         next_slot_ff  <= next_slot_in;
         busy_ff       <= busy_in;
         timeout_ff    <= timeout_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // The read address is always the slot under way, so the data stays put
   // while the sequencer waits on a stalled output.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[slot_ff] <= mem_wdata;
      end
      rd_data_ff <= slot_mem[slot_ff];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_res    = rsp_ev_ff;
   assign rsp_seq_number   = rsp_seq_ff;
   assign rsp_slot_index   = rwt_pkg::SLOT_W'(rsp_slot_ff);
   assign rsp_resend_total = rsp_tot_ff;
   assign rsp_last         = rsp_last_ff;

   // The held-back resend exists only while a timer scan is under way.
   a_pend_in_timer: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (state_ff == S_TMR_RD || state_ff == S_TMR_EV ||
                         state_ff == S_TMR_DONE))
      else $error("held resend outside a timer scan");

   // Only a grant and a resend write the slot memory.
   a_mem_write_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_ALLOC_EV || state_ff == S_TMR_EV))
      else $error("slot memory written outside grant or resend");

   // The remainder step leaves a slot index inside the window.
   a_ack_slot_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACK_RD) |-> ({1'b0, slot_ff} < (IW + 1)'(SLOTS)))
      else $error("ack slot index outside the window");

   // Every accepted allocate consumes exactly one sequence number.
   a_alloc_seq_step: assert property (@(posedge clock) disable iff (reset)
      (accept && req_type == rwt_pkg::REQ_ALLOC) |=>
         (next_seq_ff == 16'($past(next_seq_ff) + 16'd1)))
      else $error("allocate did not advance the sequence number");

endmodule
